// ----- rtl/vfpr_pkg.sv -----
// ----------------------------------------------------------------------------
// vfpr_pkg
// Types and constants shared by the video frame packet reassembler.
// ----------------------------------------------------------------------------
package vfpr_pkg;

    // Datagram header length in bytes
    localparam logic [15:0] HEADER_BYTES = 16'd16;

    // Stream codes
    localparam logic [7:0] STREAM_TOP    = 8'd0;
    localparam logic [7:0] STREAM_BOTTOM = 8'd1;

    // Configuration register reset values
    localparam logic [15:0] RST_PAYLOAD_PER_PACKET = 16'd1024;
    localparam logic [25:0] RST_HALF_FRAME_BYTES   = 26'd2764800;
    localparam logic [15:0] RST_PACKETS_PER_FRAME  = 16'd5400;
    localparam logic [26:0] RST_BUFFER_BYTES       = 27'd5529600;
    localparam logic [7:0]  RST_STALE_WINDOW       = 8'd10;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_PAYLOAD_PER_PACKET = 3'd0,
        CFG_HALF_FRAME_BYTES   = 3'd1,
        CFG_PACKETS_PER_FRAME  = 3'd2,
        CFG_BUFFER_BYTES       = 3'd3,
        CFG_CHECK_PEER         = 3'd4,
        CFG_PEER_IP_FIRST      = 3'd5,
        CFG_PEER_IP_SECOND     = 3'd6,
        CFG_STALE_WINDOW       = 3'd7
    } t_cfg_idx;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_DROP     = 2'd0,
        KIND_WRITE    = 2'd1,
        KIND_COMPLETE = 2'd2,
        KIND_RESTART  = 2'd3
    } t_kind;

    typedef struct packed {
        logic [15:0] payload_per_packet;
        logic [25:0] half_frame_bytes;
        logic [15:0] packets_per_frame;
        logic [26:0] buffer_bytes;
        logic        check_peer;
        logic [31:0] peer_ip_first;
        logic [31:0] peer_ip_second;
        logic [7:0]  stale_window;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  stream_sel;
        logic [31:0] frame_seq;
        logic [15:0] packet_index;
        logic [15:0] datagram_bytes;
        logic [31:0] sender_ip;
    } t_hdr;

    // Header after filtering and placement check
    typedef struct packed {
        logic        drop;
        logic        fits;
        logic [25:0] write_address;
        logic [15:0] write_bytes;
        logic [31:0] frame_seq;
    } t_dec;

    typedef struct packed {
        t_kind       kind;
        logic [25:0] write_address;
        logic [15:0] write_bytes;
        logic [31:0] frame_id;
        logic [15:0] count_so_far;
        logic        last;
    } t_res;

    // One or two results caused by one header
    typedef struct packed {
        logic two;
        t_res first;
        t_res second;
    } t_pair;

endpackage

// ----- rtl/vfpr_if.sv -----
// ----------------------------------------------------------------------------
// vfpr_if
// Valid/ready channels for datagram headers and reassembly results.
// ----------------------------------------------------------------------------
interface vfpr_hdr_if;
    logic        valid;
    logic        ready;
    logic [7:0]  stream_sel;
    logic [31:0] frame_seq;
    logic [15:0] packet_index;
    logic [15:0] datagram_bytes;
    logic [31:0] sender_ip;

    modport source (
        output valid, stream_sel, frame_seq, packet_index, datagram_bytes, sender_ip,
        input  ready
    );
    modport sink (
        input  valid, stream_sel, frame_seq, packet_index, datagram_bytes, sender_ip,
        output ready
    );
endinterface

interface vfpr_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [25:0] write_address;
    logic [15:0] write_bytes;
    logic [31:0] frame_id;
    logic [15:0] count_so_far;
    logic        last;

    modport source (
        output valid, kind, write_address, write_bytes, frame_id, count_so_far, last,
        input  ready
    );
    modport sink (
        input  valid, kind, write_address, write_bytes, frame_id, count_so_far, last,
        output ready
    );
endinterface

// ----- rtl/vfpr_cfg.sv -----
// ----------------------------------------------------------------------------
// vfpr_cfg
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module vfpr_cfg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_index,
    input  logic [31:0]    i_cfg_data,
    output vfpr_pkg::t_cfg o_cfg
);

    vfpr_pkg::t_cfg r_cfg;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.payload_per_packet <= vfpr_pkg::RST_PAYLOAD_PER_PACKET;
            r_cfg.half_frame_bytes   <= vfpr_pkg::RST_HALF_FRAME_BYTES;
            r_cfg.packets_per_frame  <= vfpr_pkg::RST_PACKETS_PER_FRAME;
            r_cfg.buffer_bytes       <= vfpr_pkg::RST_BUFFER_BYTES;
            r_cfg.check_peer         <= 1'b0;
            r_cfg.peer_ip_first      <= '0;
            r_cfg.peer_ip_second     <= '0;
            r_cfg.stale_window       <= vfpr_pkg::RST_STALE_WINDOW;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                vfpr_pkg::CFG_PAYLOAD_PER_PACKET: begin
                    r_cfg.payload_per_packet <= i_cfg_data[15:0];
                end
                vfpr_pkg::CFG_HALF_FRAME_BYTES: begin
                    r_cfg.half_frame_bytes <= i_cfg_data[25:0];
                end
                vfpr_pkg::CFG_PACKETS_PER_FRAME: begin
                    r_cfg.packets_per_frame <= i_cfg_data[15:0];
                end
                vfpr_pkg::CFG_BUFFER_BYTES: begin
                    r_cfg.buffer_bytes <= i_cfg_data[26:0];
                end
                vfpr_pkg::CFG_CHECK_PEER: begin
                    r_cfg.check_peer <= i_cfg_data[0];
                end
                vfpr_pkg::CFG_PEER_IP_FIRST: begin
                    r_cfg.peer_ip_first <= i_cfg_data;
                end
                vfpr_pkg::CFG_PEER_IP_SECOND: begin
                    r_cfg.peer_ip_second <= i_cfg_data;
                end
                vfpr_pkg::CFG_STALE_WINDOW: begin
                    r_cfg.stale_window <= i_cfg_data[7:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/vfpr_addr.sv -----
// ----------------------------------------------------------------------------
// vfpr_addr
// Header input register, address multiply, sender filter and fit check.
// ----------------------------------------------------------------------------
module vfpr_addr (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  vfpr_pkg::t_cfg i_cfg,
    vfpr_hdr_if.sink       i_hdr,
    output logic           o_dec_vld,
    output vfpr_pkg::t_dec o_dec,
    input  logic           i_dec_rdy
);

    logic           r_a_vld;
    vfpr_pkg::t_hdr r_a_hdr;
    logic           r_b_vld;
    vfpr_pkg::t_hdr r_b_hdr;
    logic [31:0]    r_b_prod;
    logic           r_c_vld;
    vfpr_pkg::t_dec r_c_dec;

    logic           a_rdy;
    logic           b_rdy;
    logic           c_rdy;
    logic [31:0]    a_prod;
    logic [32:0]    b_addr;
    logic [33:0]    b_end;
    logic [15:0]    b_bytes;
    logic           b_short;
    logic           b_reject;
    vfpr_pkg::t_dec b_dec;

    // Stage handshakes: a stage loads when empty or when it moves on
    assign c_rdy       = !r_c_vld || i_dec_rdy;
    assign b_rdy       = !r_b_vld || c_rdy;
    assign a_rdy       = !r_a_vld || b_rdy;
    assign i_hdr.ready = a_rdy;

    // Stage A: input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (a_rdy) begin
            r_a_vld <= i_hdr.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_rdy && i_hdr.valid) begin
            r_a_hdr.stream_sel     <= i_hdr.stream_sel;
            r_a_hdr.frame_seq      <= i_hdr.frame_seq;
            r_a_hdr.packet_index   <= i_hdr.packet_index;
            r_a_hdr.datagram_bytes <= i_hdr.datagram_bytes;
            r_a_hdr.sender_ip      <= i_hdr.sender_ip;
        end
    end

    // Packet offset within its half frame
    assign a_prod = {16'd0, r_a_hdr.packet_index} * {16'd0, i_cfg.payload_per_packet};

    // Stage B: product register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (b_rdy) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_rdy && r_a_vld) begin
            r_b_hdr  <= r_a_hdr;
            r_b_prod <= a_prod;
        end
    end

    // Half-frame offset, payload length, drop filter and fit against the buffer end
    always_comb begin
        b_addr   = {1'b0, r_b_prod}
                 + ((r_b_hdr.stream_sel == vfpr_pkg::STREAM_BOTTOM)
                    ? {7'd0, i_cfg.half_frame_bytes} : 33'd0);
        b_bytes  = r_b_hdr.datagram_bytes - vfpr_pkg::HEADER_BYTES;
        b_short  = r_b_hdr.datagram_bytes < vfpr_pkg::HEADER_BYTES;
        b_end    = {1'b0, b_addr} + {18'd0, b_bytes};
        b_reject = i_cfg.check_peer
                && (r_b_hdr.sender_ip != i_cfg.peer_ip_first)
                && (r_b_hdr.sender_ip != i_cfg.peer_ip_second);

        b_dec.drop          = b_reject || (r_b_hdr.stream_sel > vfpr_pkg::STREAM_BOTTOM);
        b_dec.fits          = !b_short && (b_end <= {7'd0, i_cfg.buffer_bytes});
        b_dec.write_address = b_addr[25:0];
        b_dec.write_bytes   = b_bytes;
        b_dec.frame_seq     = r_b_hdr.frame_seq;
    end

    // Stage C: decision input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (c_rdy) begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_rdy && r_b_vld) begin
            r_c_dec <= b_dec;
        end
    end

    assign o_dec_vld = r_c_vld;
    assign o_dec     = r_c_dec;

endmodule

// ----- rtl/vfpr_ctrl.sv -----
// ----------------------------------------------------------------------------
// vfpr_ctrl
// Frame tracking: restart, placement, counting and completion decisions.
// ----------------------------------------------------------------------------
module vfpr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  vfpr_pkg::t_cfg  i_cfg,
    input  logic            i_dec_vld,
    input  vfpr_pkg::t_dec  i_dec,
    output logic            o_dec_rdy,
    output logic            o_pair_vld,
    output vfpr_pkg::t_pair o_pair,
    input  logic            i_pair_rdy
);

    logic [31:0] r_frame_now;
    logic [15:0] r_placed_count;
    logic [31:0] n_frame_now;
    logic [15:0] n_placed_count;

    logic        fire;
    logic        newer;
    logic        stale;
    logic        restart;
    logic        place_ok;
    logic        complete;
    logic [15:0] base_cnt;
    logic [15:0] cnt_inc;
    logic [31:0] base_frame;
    logic [32:0] window_end;
    vfpr_pkg::t_res res_place;
    vfpr_pkg::t_res res_restart;
    vfpr_pkg::t_res res_drop;

    assign fire       = i_dec_vld && i_pair_rdy;
    assign o_dec_rdy  = i_pair_rdy;
    assign o_pair_vld = i_dec_vld;

    // Frame decision and result assembly
    always_comb begin
        newer      = r_frame_now < i_dec.frame_seq;
        window_end = {1'b0, i_dec.frame_seq} + {25'd0, i_cfg.stale_window};
        stale      = window_end < {1'b0, r_frame_now};
        restart    = !i_dec.drop && (newer || stale);
        place_ok   = !i_dec.drop && i_dec.fits
                  && (restart || (i_dec.frame_seq == r_frame_now));
        base_cnt   = restart ? 16'd0 : r_placed_count;
        base_frame = restart ? i_dec.frame_seq : r_frame_now;
        cnt_inc    = base_cnt + 16'd1;
        complete   = cnt_inc == i_cfg.packets_per_frame;

        res_place.kind          = complete ? vfpr_pkg::KIND_COMPLETE : vfpr_pkg::KIND_WRITE;
        res_place.write_address = i_dec.write_address;
        res_place.write_bytes   = i_dec.write_bytes;
        res_place.frame_id      = base_frame;
        res_place.count_so_far  = cnt_inc;
        res_place.last          = 1'b1;

        res_restart.kind          = vfpr_pkg::KIND_RESTART;
        res_restart.write_address = '0;
        res_restart.write_bytes   = '0;
        res_restart.frame_id      = i_dec.frame_seq;
        res_restart.count_so_far  = '0;
        res_restart.last          = !place_ok;

        res_drop.kind          = vfpr_pkg::KIND_DROP;
        res_drop.write_address = '0;
        res_drop.write_bytes   = '0;
        res_drop.frame_id      = r_frame_now;
        res_drop.count_so_far  = r_placed_count;
        res_drop.last          = 1'b1;

        if (restart) begin
            o_pair.two    = place_ok;
            o_pair.first  = res_restart;
            o_pair.second = res_place;
        end else begin
            o_pair.two    = 1'b0;
            o_pair.first  = place_ok ? res_place : res_drop;
            o_pair.second = res_place;
        end

        // Next frame state
        n_frame_now    = r_frame_now;
        n_placed_count = r_placed_count;
        if (place_ok) begin
            if (complete) begin
                n_frame_now    = base_frame + 32'd1;
                n_placed_count = 16'd0;
            end else begin
                n_frame_now    = base_frame;
                n_placed_count = cnt_inc;
            end
        end else if (restart) begin
            n_frame_now    = i_dec.frame_seq;
            n_placed_count = 16'd0;
        end
    end

    // Frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_now    <= '0;
            r_placed_count <= '0;
        end else if (fire) begin
            r_frame_now    <= n_frame_now;
            r_placed_count <= n_placed_count;
        end
    end

`ifndef NO_ASSERTIONS
    a_complete_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && place_ok && complete |=> r_placed_count == 16'd0)
        else $error("placed count not cleared after frame completion");

    a_restart_takes_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && restart && !place_ok |=> r_frame_now == $past(i_dec.frame_seq))
        else $error("restart did not adopt the new frame number");
`endif

endmodule

// ----- rtl/vfpr_out.sv -----
// ----------------------------------------------------------------------------
// vfpr_out
// Result register: holds the one or two results of a header and hands
// them out one item at a time.
// ----------------------------------------------------------------------------
module vfpr_out (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_pair_vld,
    input  vfpr_pkg::t_pair i_pair,
    output logic            o_pair_rdy,
    vfpr_res_if.source      o_res
);

    logic           r_vld;
    logic           r_two;
    vfpr_pkg::t_res r_slot0;
    vfpr_pkg::t_res r_slot1;
    logic           out_fire;
    logic           load;

    assign out_fire   = r_vld && o_res.ready;
    assign o_pair_rdy = !r_vld || (out_fire && !r_two);
    assign load       = i_pair_vld && o_pair_rdy;

    // Control: valid and second-result flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_two <= 1'b0;
        end else if (load) begin
            r_vld <= 1'b1;
            r_two <= i_pair.two;
        end else if (out_fire) begin
            if (r_two) begin
                r_two <= 1'b0;
            end else begin
                r_vld <= 1'b0;
            end
        end
    end

    // Payload: second result moves up after the first is taken
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_slot0 <= i_pair.first;
            r_slot1 <= i_pair.second;
        end else if (out_fire && r_two) begin
            r_slot0 <= r_slot1;
        end
    end

    assign o_res.valid         = r_vld;
    assign o_res.kind          = r_slot0.kind;
    assign o_res.write_address = r_slot0.write_address;
    assign o_res.write_bytes   = r_slot0.write_bytes;
    assign o_res.frame_id      = r_slot0.frame_id;
    assign o_res.count_so_far  = r_slot0.count_so_far;
    assign o_res.last          = r_slot0.last;

`ifndef NO_ASSERTIONS
    a_two_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_two |-> r_vld)
        else $error("second result pending without a valid result");

    a_not_last_has_more: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && !r_slot0.last |-> r_two)
        else $error("non-final result shown with no result following");
`endif

endmodule

// ----- rtl/video_frame_packet_reassembler_top.sv -----
// ----------------------------------------------------------------------------
// video_frame_packet_reassembler_top
// Decides where each received video datagram payload goes in a frame buffer.
// ----------------------------------------------------------------------------
// Usage:
//   i_hdr carries one datagram header per item (stream, frame number, packet
//   index, datagram length, sender address). o_res carries result items:
//   dropped, payload write, frame-completing write, or frame restart; the
//   final result of a header has last set.
//   Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data
//   while no header is in flight.
//   Path: input register, product register and decision input register,
//   then the frame decision loads the result register that presents it.
//   Throughput: one header per cycle while o_res is ready. A restart that
//   also places the payload produces two results, handed out one at a time;
//   the result register holding them is the limit.
//   Reset clears the pipeline, sets frame number and placed count to zero
//   and loads the configuration defaults.
//   When o_res is stalled the pipeline stages fill and i_hdr.ready drops
//   once all are full; nothing is lost.
// ----------------------------------------------------------------------------
module video_frame_packet_reassembler_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    vfpr_hdr_if.sink    i_hdr,
    vfpr_res_if.source  o_res
);

    vfpr_pkg::t_cfg  cfg;
    logic            dec_vld;
    logic            dec_rdy;
    vfpr_pkg::t_dec  dec;
    logic            pair_vld;
    logic            pair_rdy;
    vfpr_pkg::t_pair pair;

    vfpr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    vfpr_addr u_addr (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_hdr     (i_hdr),
        .o_dec_vld (dec_vld),
        .o_dec     (dec),
        .i_dec_rdy (dec_rdy)
    );

    vfpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_dec_vld  (dec_vld),
        .i_dec      (dec),
        .o_dec_rdy  (dec_rdy),
        .o_pair_vld (pair_vld),
        .o_pair     (pair),
        .i_pair_rdy (pair_rdy)
    );

    vfpr_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pair_vld (pair_vld),
        .i_pair     (pair),
        .o_pair_rdy (pair_rdy),
        .o_res      (o_res)
    );

endmodule

// ----- tb/sv/tb_video_frame_packet_reassembler_top.sv -----
// ----------------------------------------------------------------------------
// tb_video_frame_packet_reassembler_top
// Self-checking bench for the video frame packet reassembler. A short
// directed table covers filtering, stale and newer frames, short datagrams,
// the buffer bound and the 26-bit address wrap. Random phases follow, each
// with its own register setting; handshake pressure changes per phase pair.
// Each result is compared field by field to its row or the behavioral model.
// ----------------------------------------------------------------------------
module tb_video_frame_packet_reassembler_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CLK_HALF_NS   = 6;
    localparam int  TIMEOUT_NS    = 5_000_000;
    localparam int  PHASE_ITEMS   = 205;
    localparam int  NUM_PHASES    = 6;
    localparam int  HOLD_CYCLES   = 64;
    localparam int  MAX_REPORTS   = 10;

    // One directed step: a register write or a header item
    typedef struct packed {
        logic               is_cfg;
        vfpr_pkg::t_cfg_idx cidx;
        logic [31:0]        cdata;
        vfpr_pkg::t_hdr     hdr;
        logic               typed;
        vfpr_pkg::t_res     exp;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    vfpr_hdr_if hdr_if ();
    vfpr_res_if res_if ();

    video_frame_packet_reassembler_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_hdr       (hdr_if),
        .o_res       (res_if)
    );

    // Model state and register copy
    vfpr_pkg::t_cfg cfg_m;
    logic [31:0]    frame_cur;
    logic [15:0]    placed_cnt;

    vfpr_pkg::t_res exp_res_q [$];
    t_row           dir_tab [$];

    logic           row_typed;
    vfpr_pkg::t_res row_exp;

    int          snd_idle_pct;
    int          rcv_idle_pct;
    int          hdr_acc_cnt;
    int          res_chk_cnt;
    int          err_cnt;
    int          n_drop, n_write, n_complete, n_restart;

    bit          pressure_arm;
    bit          pressure_done;
    int          pressure_at;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF_NS) i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("video_frame_packet_reassembler_top verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Reassembly model
    // ------------------------------------------------------------------------

    function automatic vfpr_pkg::t_res drop_res();
        vfpr_pkg::t_res r;
        r = '0;
        r.kind = vfpr_pkg::KIND_DROP;
        r.frame_id = frame_cur;
        r.count_so_far = placed_cnt;
        r.last = 1'b1;
        return r;
    endfunction

    // Place payload in the current frame; fit test in full width
    function automatic void place_payload(input vfpr_pkg::t_hdr h, output bit placed,
                                          output vfpr_pkg::t_res r);
        logic [63:0] addr;
        logic [63:0] nbytes;
        placed = 1'b0;
        r = '0;
        if (h.datagram_bytes < vfpr_pkg::HEADER_BYTES) return;
        nbytes = 64'(h.datagram_bytes - vfpr_pkg::HEADER_BYTES);
        addr = 64'(h.packet_index) * 64'(cfg_m.payload_per_packet) +
               ((h.stream_sel == vfpr_pkg::STREAM_BOTTOM) ?
                64'(cfg_m.half_frame_bytes) : 64'd0);
        if (addr + nbytes > 64'(cfg_m.buffer_bytes)) return;
        placed = 1'b1;
        placed_cnt = placed_cnt + 16'd1;
        r.write_address = addr[25:0];
        r.write_bytes = nbytes[15:0];
        r.frame_id = frame_cur;
        r.count_so_far = placed_cnt;
        r.last = 1'b1;
        if (placed_cnt == cfg_m.packets_per_frame) begin
            r.kind = vfpr_pkg::KIND_COMPLETE;
            frame_cur = frame_cur + 32'd1;
            placed_cnt = '0;
        end else begin
            r.kind = vfpr_pkg::KIND_WRITE;
        end
    endfunction

    // Returns the number of results one header causes
    function automatic int reassemble_hdr(input vfpr_pkg::t_hdr h,
                                          output vfpr_pkg::t_res r0,
                                          output vfpr_pkg::t_res r1);
        bit             rejected;
        bit             placed;
        vfpr_pkg::t_res w;
        r0 = '0;
        r1 = '0;
        rejected = cfg_m.check_peer && (h.sender_ip != cfg_m.peer_ip_first) &&
                   (h.sender_ip != cfg_m.peer_ip_second);
        if (rejected || h.stream_sel > vfpr_pkg::STREAM_BOTTOM) begin
            r0 = drop_res();
            return 1;
        end
        // Newer frame, or older than the window allows: restart
        if (frame_cur < h.frame_seq ||
            64'(h.frame_seq) + 64'(cfg_m.stale_window) < 64'(frame_cur)) begin
            frame_cur = h.frame_seq;
            placed_cnt = '0;
            r0.kind = vfpr_pkg::KIND_RESTART;
            r0.frame_id = h.frame_seq;
            place_payload(h, placed, w);
            r0.last = !placed;
            r1 = w;
            return placed ? 2 : 1;
        end
        if (h.frame_seq == frame_cur) begin
            place_payload(h, placed, w);
            if (placed) begin
                r0 = w;
                return 1;
            end
        end
        r0 = drop_res();
        return 1;
    endfunction

    function automatic string res_str(vfpr_pkg::t_res r);
        return $sformatf("kind=%0d addr=0x%07h bytes=%0d frame=0x%08h count=%0d last=%0d",
                         r.kind, r.write_address, r.write_bytes, r.frame_id,
                         r.count_so_far, r.last);
    endfunction

    // ------------------------------------------------------------------------
    // Directed table builders
    // ------------------------------------------------------------------------

    function automatic t_row item_row(logic [7:0] s, logic [31:0] f, logic [15:0] i,
                                      logic [15:0] b, logic [31:0] ip);
        t_row r;
        r = '0;
        r.hdr.stream_sel = s;
        r.hdr.frame_seq = f;
        r.hdr.packet_index = i;
        r.hdr.datagram_bytes = b;
        r.hdr.sender_ip = ip;
        return r;
    endfunction

    function automatic t_row fixed_row(logic [7:0] s, logic [31:0] f, logic [15:0] i,
                                       logic [15:0] b, logic [31:0] ip, vfpr_pkg::t_kind k,
                                       logic [25:0] a, logic [15:0] n, logic [31:0] fid,
                                       logic [15:0] c);
        t_row r;
        r = item_row(s, f, i, b, ip);
        r.typed = 1'b1;
        r.exp.kind = k;
        r.exp.write_address = a;
        r.exp.write_bytes = n;
        r.exp.frame_id = fid;
        r.exp.count_so_far = c;
        r.exp.last = 1'b1;
        return r;
    endfunction

    function automatic t_row reg_row(vfpr_pkg::t_cfg_idx c, logic [31:0] d);
        t_row r;
        r = '0;
        r.is_cfg = 1'b1;
        r.cidx = c;
        r.cdata = d;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Register write at the next rising edge; caller lowers the enable
    task automatic write_reg(input vfpr_pkg::t_cfg_idx idx, input logic [31:0] d);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        case (idx)
            vfpr_pkg::CFG_PAYLOAD_PER_PACKET: cfg_m.payload_per_packet = d[15:0];
            vfpr_pkg::CFG_HALF_FRAME_BYTES:   cfg_m.half_frame_bytes = d[25:0];
            vfpr_pkg::CFG_PACKETS_PER_FRAME:  cfg_m.packets_per_frame = d[15:0];
            vfpr_pkg::CFG_BUFFER_BYTES:       cfg_m.buffer_bytes = d[26:0];
            vfpr_pkg::CFG_CHECK_PEER:         cfg_m.check_peer = d[0];
            vfpr_pkg::CFG_PEER_IP_FIRST:      cfg_m.peer_ip_first = d;
            vfpr_pkg::CFG_PEER_IP_SECOND:     cfg_m.peer_ip_second = d;
            vfpr_pkg::CFG_STALE_WINDOW:       cfg_m.stale_window = d[7:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Offer one header item with random leading gaps; returns at the negedge after accept
    task automatic send_hdr(input vfpr_pkg::t_hdr h);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            hdr_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        hdr_if.valid <= 1'b1;
        hdr_if.stream_sel <= h.stream_sel;
        hdr_if.frame_seq <= h.frame_seq;
        hdr_if.packet_index <= h.packet_index;
        hdr_if.datagram_bytes <= h.datagram_bytes;
        hdr_if.sender_ip <= h.sender_ip;
        do @(posedge i_clk); while (!(hdr_if.valid && hdr_if.ready));
        @(negedge i_clk);
    endtask

    // Stop offering and wait until every expected result is back
    task automatic drain_results();
        hdr_if.valid <= 1'b0;
        do @(negedge i_clk); while (exp_res_q.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_idle_mode(input int mode);
        case (mode)
            0:       begin snd_idle_pct = 11; rcv_idle_pct = 50; end
            1:       begin snd_idle_pct = 50; rcv_idle_pct = 11; end
            default: begin snd_idle_pct = 0;  rcv_idle_pct = 0;  end
        endcase
    endtask

    // Result receiver: random stalls plus one long hold-off when armed
    initial begin : rcv_proc
        int stall_left;
        stall_left = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                res_if.ready <= 1'b0;
                stall_left--;
            end else if (pressure_arm && !pressure_done && hdr_acc_cnt >= pressure_at) begin
                pressure_done = 1'b1;
                stall_left = HOLD_CYCLES - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on header accept, check on result accept
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : mon
        vfpr_pkg::t_hdr h;
        vfpr_pkg::t_res r0, r1, e, a;
        int             n;
        if (i_rst_n) begin
            if (hdr_if.valid && hdr_if.ready) begin
                h.stream_sel = hdr_if.stream_sel;
                h.frame_seq = hdr_if.frame_seq;
                h.packet_index = hdr_if.packet_index;
                h.datagram_bytes = hdr_if.datagram_bytes;
                h.sender_ip = hdr_if.sender_ip;
                n = reassemble_hdr(h, r0, r1);
                if (row_typed) begin
                    exp_res_q.push_back(row_exp);
                end else begin
                    exp_res_q.push_back(r0);
                    if (n == 2) exp_res_q.push_back(r1);
                end
                hdr_acc_cnt++;
            end
            if (res_if.valid && res_if.ready) begin
                a.kind = vfpr_pkg::t_kind'(res_if.kind);
                a.write_address = res_if.write_address;
                a.write_bytes = res_if.write_bytes;
                a.frame_id = res_if.frame_id;
                a.count_so_far = res_if.count_so_far;
                a.last = res_if.last;
                if (exp_res_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("%0t: unexpected result %s", $realtime, res_str(a));
                end else begin
                    e = exp_res_q.pop_front();
                    res_chk_cnt++;
                    case (e.kind)
                        vfpr_pkg::KIND_DROP:     n_drop++;
                        vfpr_pkg::KIND_WRITE:    n_write++;
                        vfpr_pkg::KIND_COMPLETE: n_complete++;
                        default:                 n_restart++;
                    endcase
                    if (a.kind !== e.kind || a.write_address !== e.write_address ||
                        a.write_bytes !== e.write_bytes || a.frame_id !== e.frame_id ||
                        a.count_so_far !== e.count_so_far || a.last !== e.last) begin
                        err_cnt++;
                        if (err_cnt <= MAX_REPORTS) begin
                            $display("%0t: result %0d mismatch", $realtime, res_chk_cnt);
                            $display("    exp %s", res_str(e));
                            $display("    got %s", res_str(a));
                        end
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stim
        vfpr_pkg::t_hdr h;
        vfpr_pkg::t_cfg cfg_next;
        int             k, p, it, sel, lim, span;
        bit             cfg_open;

        // Known values on every input from time zero
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        hdr_if.valid = 1'b0;
        hdr_if.stream_sel = '0;
        hdr_if.frame_seq = '0;
        hdr_if.packet_index = '0;
        hdr_if.datagram_bytes = '0;
        hdr_if.sender_ip = '0;

        cfg_m = '{vfpr_pkg::RST_PAYLOAD_PER_PACKET, vfpr_pkg::RST_HALF_FRAME_BYTES,
                  vfpr_pkg::RST_PACKETS_PER_FRAME, vfpr_pkg::RST_BUFFER_BYTES, 1'b0,
                  32'd0, 32'd0, vfpr_pkg::RST_STALE_WINDOW};
        frame_cur = '0;
        placed_cnt = '0;
        row_typed = 1'b0;
        row_exp = '0;
        hdr_acc_cnt = 0;
        res_chk_cnt = 0;
        err_cnt = 0;
        n_drop = 0; n_write = 0; n_complete = 0; n_restart = 0;
        pressure_arm = 1'b0;
        pressure_done = 1'b0;
        pressure_at = 0;
        cfg_open = 1'b0;
        set_idle_mode(0);

        // Directed: reset registers, frame 0, nothing placed yet
        dir_tab.push_back(fixed_row(8'd2, 32'd0, 16'd0, 16'd1040, 32'd0,
                                    vfpr_pkg::KIND_DROP, 26'd0, 16'd0, 32'd0, 16'd0));
        dir_tab.push_back(fixed_row(8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                                    vfpr_pkg::KIND_DROP, 26'd0, 16'd0, 32'd0, 16'd0));
        dir_tab.push_back(fixed_row(8'd0, 32'd0, 16'd0, 16'd1040, 32'd0,
                                    vfpr_pkg::KIND_WRITE, 26'd0, 16'd1024, 32'd0, 16'd1));
        dir_tab.push_back(item_row(8'd1, 32'd0, 16'd1, 16'd1040, 32'h0A00_0001));
        // Far past the buffer end
        dir_tab.push_back(fixed_row(8'd0, 32'd0, 16'hFFFF, 16'hFFFF, 32'd0,
                                    vfpr_pkg::KIND_DROP, 26'd0, 16'd0, 32'd0, 16'd2));
        // Shorter than the header
        dir_tab.push_back(fixed_row(8'd0, 32'd0, 16'd0, 16'd15, 32'd0,
                                    vfpr_pkg::KIND_DROP, 26'd0, 16'd0, 32'd0, 16'd2));
        dir_tab.push_back(item_row(8'd0, 32'd0, 16'd0, 16'd16, 32'd0));
        // Newer frame restarts, older within window drops
        dir_tab.push_back(item_row(8'd0, 32'd5, 16'd2, 16'd1040, 32'd0));
        dir_tab.push_back(item_row(8'd1, 32'd0, 16'd0, 16'd1040, 32'd0));
        dir_tab.push_back(item_row(8'd1, 32'hFFFF_FFFF, 16'd0, 16'd1040, 32'd0));
        // Stale beyond window restarts, payload does not fit
        dir_tab.push_back(item_row(8'd0, 32'd0, 16'hFFFF, 16'd1040, 32'd0));
        // Peer filter on, zero window, half frame 2^25 and buffer 2^26 bytes
        dir_tab.push_back(reg_row(vfpr_pkg::CFG_CHECK_PEER, 32'd1));
        dir_tab.push_back(reg_row(vfpr_pkg::CFG_PEER_IP_FIRST, 32'hC0A8_0001));
        dir_tab.push_back(reg_row(vfpr_pkg::CFG_PEER_IP_SECOND, 32'hFFFF_FFFF));
        dir_tab.push_back(reg_row(vfpr_pkg::CFG_STALE_WINDOW, 32'd0));
        dir_tab.push_back(reg_row(vfpr_pkg::CFG_PAYLOAD_PER_PACKET, 32'd1024));
        dir_tab.push_back(reg_row(vfpr_pkg::CFG_HALF_FRAME_BYTES, 32'h0200_0000));
        dir_tab.push_back(reg_row(vfpr_pkg::CFG_BUFFER_BYTES, 32'h0400_0000));
        dir_tab.push_back(reg_row(vfpr_pkg::CFG_PACKETS_PER_FRAME, 32'd2));
        dir_tab.push_back(fixed_row(8'd0, 32'd0, 16'd0, 16'd1040, 32'h1234_5678,
                                    vfpr_pkg::KIND_DROP, 26'd0, 16'd0, 32'd0, 16'd0));
        // Address exactly 2^26 with empty payload: fits, wraps to zero
        dir_tab.push_back(item_row(8'd1, 32'd0, 16'd32768, 16'd16, 32'hFFFF_FFFF));
        dir_tab.push_back(item_row(8'd1, 32'd0, 16'd32768, 16'd17, 32'hC0A8_0001));
        dir_tab.push_back(item_row(8'd0, 32'd0, 16'd5, 16'd1040, 32'hC0A8_0001));
        dir_tab.push_back(item_row(8'd0, 32'd0, 16'd0, 16'd100, 32'hFFFF_FFFF));
        dir_tab.push_back(item_row(8'd0, 32'd1, 16'd0, 16'd1040, 32'hC0A8_0001));
        // Zero frame size, one-byte buffer, widest window
        dir_tab.push_back(reg_row(vfpr_pkg::CFG_PACKETS_PER_FRAME, 32'd0));
        dir_tab.push_back(reg_row(vfpr_pkg::CFG_PAYLOAD_PER_PACKET, 32'd65535));
        dir_tab.push_back(reg_row(vfpr_pkg::CFG_STALE_WINDOW, 32'd255));
        dir_tab.push_back(reg_row(vfpr_pkg::CFG_BUFFER_BYTES, 32'd1));
        dir_tab.push_back(reg_row(vfpr_pkg::CFG_HALF_FRAME_BYTES, 32'd1));
        dir_tab.push_back(reg_row(vfpr_pkg::CFG_CHECK_PEER, 32'd0));
        dir_tab.push_back(item_row(8'd0, 32'd1, 16'd0, 16'd17, 32'd0));
        dir_tab.push_back(item_row(8'd1, 32'd1, 16'd0, 16'd16, 32'd0));
        dir_tab.push_back(item_row(8'd1, 32'd1, 16'd0, 16'd17, 32'd0));
        dir_tab.push_back(item_row(8'd0, 32'd1, 16'd1, 16'd16, 32'hFFFF_FFFF));
        dir_tab.push_back(item_row(8'd0, 32'd0, 16'd0, 16'd16, 32'd0));

        // Reset
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Walk the directed table
        for (k = 0; k < dir_tab.size(); k++) begin
            if (dir_tab[k].is_cfg) begin
                if (!cfg_open) begin
                    drain_results();
                    cfg_open = 1'b1;
                end
                write_reg(dir_tab[k].cidx, dir_tab[k].cdata);
            end else begin
                if (cfg_open) begin
                    i_cfg_we <= 1'b0;
                    cfg_open = 1'b0;
                end
                row_typed = dir_tab[k].typed;
                row_exp = dir_tab[k].exp;
                send_hdr(dir_tab[k].hdr);
            end
        end
        row_typed = 1'b0;

        // Random phases, one register setting each
        for (p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            // Fields: payload, half frame, frame size, buffer, peer check, peers, window
            case (p)
                0: begin
                    cfg_next = '{16'd64, 26'd4096, 16'd6, 27'd8192, 1'b1,
                                 32'($urandom), 32'($urandom), 8'd3};
                    span = 70;
                end
                1: begin
                    cfg_next = '{16'd65535, 26'h200_0000, 16'd1, 27'h400_0000, 1'b0,
                                 32'hFFFF_FFFF, 32'd0, 8'd255};
                    span = 600;
                end
                2: begin
                    cfg_next = '{16'd1, 26'd1, 16'd0, 27'd1, 1'b1,
                                 32'($urandom), 32'hFFFF_FFFF, 8'd0};
                    span = 2;
                end
                3: begin
                    cfg_next = '{16'd1500, 26'd24000, 16'd32, 27'd48000, 1'b0,
                                 32'd0, 32'd0, 8'd10};
                    span = 17;
                end
                4: begin
                    cfg_next = '{16'd4096, 26'd16384, 16'd65535, 27'd32768, 1'b1,
                                 32'd0, 32'($urandom), 8'd200};
                    span = 4;
                end
                default: begin
                    cfg_next = '{vfpr_pkg::RST_PAYLOAD_PER_PACKET,
                                 vfpr_pkg::RST_HALF_FRAME_BYTES, 16'd12,
                                 vfpr_pkg::RST_BUFFER_BYTES, 1'b0, 32'd0, 32'd0,
                                 vfpr_pkg::RST_STALE_WINDOW};
                    span = 20;
                end
            endcase
            write_reg(vfpr_pkg::CFG_PAYLOAD_PER_PACKET, 32'(cfg_next.payload_per_packet));
            write_reg(vfpr_pkg::CFG_HALF_FRAME_BYTES, 32'(cfg_next.half_frame_bytes));
            write_reg(vfpr_pkg::CFG_PACKETS_PER_FRAME, 32'(cfg_next.packets_per_frame));
            write_reg(vfpr_pkg::CFG_BUFFER_BYTES, 32'(cfg_next.buffer_bytes));
            write_reg(vfpr_pkg::CFG_CHECK_PEER, 32'(cfg_next.check_peer));
            write_reg(vfpr_pkg::CFG_PEER_IP_FIRST, cfg_next.peer_ip_first);
            write_reg(vfpr_pkg::CFG_PEER_IP_SECOND, cfg_next.peer_ip_second);
            write_reg(vfpr_pkg::CFG_STALE_WINDOW, 32'(cfg_next.stale_window));
            i_cfg_we <= 1'b0;
            set_idle_mode(p / 2);
            // Long receiver hold-off early in the second phase
            if (p == 1) begin
                pressure_at = hdr_acc_cnt + 20;
                pressure_arm = 1'b1;
            end

            for (it = 0; it < PHASE_ITEMS; it++) begin
                sel = $urandom_range(0, 99);
                // Well-formed header for the current frame
                h.stream_sel = 8'($urandom_range(0, 1));
                h.frame_seq = frame_cur;
                h.packet_index = 16'($urandom_range(0, span));
                lim = int'(cfg_m.payload_per_packet) + 16;
                if (lim > 65535) lim = 65535;
                h.datagram_bytes = ($urandom_range(0, 4) == 0) ?
                                   16'($urandom_range(16, lim)) : 16'(lim);
                if (cfg_m.check_peer)
                    h.sender_ip = $urandom_range(0, 1) ? cfg_m.peer_ip_first
                                                       : cfg_m.peer_ip_second;
                else
                    h.sender_ip = $urandom;
                if ($urandom_range(0, 9) == 0) h.sender_ip = $urandom;
                // Frame number variants and raw noise
                if (sel >= 62 && sel < 72)
                    h.frame_seq = frame_cur + 32'($urandom_range(1, 3));
                else if (sel >= 72 && sel < 80)
                    h.frame_seq = frame_cur - 32'($urandom_range(0, cfg_m.stale_window));
                else if (sel >= 80 && sel < 86)
                    h.frame_seq = frame_cur - 32'(cfg_m.stale_window) -
                                  32'($urandom_range(1, 50));
                else if (sel >= 86) begin
                    h.stream_sel = 8'($urandom_range(0, 255));
                    h.frame_seq = $urandom;
                    h.packet_index = 16'($urandom);
                    h.datagram_bytes = 16'($urandom);
                    h.sender_ip = $urandom;
                end
                send_hdr(h);
            end
        end

        drain_results();
        repeat (8) @(negedge i_clk);

        $display("Run covered %0d header items and %0d result items in %0d phases.",
                 hdr_acc_cnt, res_chk_cnt, NUM_PHASES + 1);
        $display("Results: %0d writes, %0d frame completions, %0d restarts, %0d drops.",
                 n_write, n_complete, n_restart, n_drop);
        if (err_cnt == 0 && exp_res_q.size() == 0) begin
            $display("video_frame_packet_reassembler_top verification clean");
        end else begin
            $display("%0d failures, %0d results still expected", err_cnt, exp_res_q.size());
            $display("video_frame_packet_reassembler_top verification failed");
        end
        $finish;
    end

endmodule
